FILE: rtl/dop_pkg.sv
// shared types, option codes and queue sizes for the dhcp option parser
package dop_pkg;

   // standard option numbers
   localparam logic [7:0] OPT_PAD     = 8'd0;
   localparam logic [7:0] OPT_MASK    = 8'd1;
   localparam logic [7:0] OPT_ROUTER  = 8'd3;
   localparam logic [7:0] OPT_DNS     = 8'd6;
   localparam logic [7:0] OPT_LEASE   = 8'd51;
   localparam logic [7:0] OPT_MSGTYPE = 8'd53;
   localparam logic [7:0] OPT_SERVER  = 8'd54;
   localparam logic [7:0] OPT_END     = 8'd255;

   // number of value bytes kept per record
   localparam logic [2:0] MAX_VALUE_BYTES = 3'd4;

   // default queue depths (powers of two)
   localparam int MID_DEPTH_DEFAULT = 4;
   localparam int RSP_DEPTH_DEFAULT = 2;

   // option kinds the walker cares about
   typedef enum logic [2:0] {
      KIND_OTHER   = 3'd0,
      KIND_MASK    = 3'd1,
      KIND_ROUTER  = 3'd2,
      KIND_DNS     = 3'd3,
      KIND_LEASE   = 3'd4,
      KIND_MSGTYPE = 3'd5,
      KIND_SERVER  = 3'd6
   } dop_kind_type;

   // walker phase, one-hot
   typedef enum logic [3:0] {
      PH_CODE = 4'b0001,
      PH_LEN  = 4'b0010,
      PH_DATA = 4'b0100,
      PH_DONE = 4'b1000
   } dop_phase_type;

   // input item
   typedef struct packed {
      logic [7:0] opt_byte;
      logic       last;
   } dop_req_type;

   // classified byte between front and back
   typedef struct packed {
      logic [7:0]   opt_byte;
      logic         last;
      logic         is_end;
      logic         is_pad;
      dop_kind_type kind;
   } dop_cls_type;

   // result item
   typedef struct packed {
      logic [7:0]  msg_type;
      logic        has_msg_type;
      logic [31:0] subnet_mask;
      logic [31:0] dns_server;
      logic [31:0] router;
      logic [31:0] server_id;
      logic [31:0] lease_seconds;
      logic        has_lease;
      logic        truncated;
   } dop_rsp_type;

endpackage

FILE: rtl/dop_queue.sv
// small first-in first-out queue of register entries
module dop_queue
   import dop_pkg::*;
#(
   parameter int  DEPTH = 4,
   parameter type item_type = dop_req_type
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  item_type in_item,
   input  logic     pop,
   output logic     empty,
   output item_type out_item
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [CntWidth-1:0] DepthCount = CntWidth'(DEPTH);

   item_type              entry_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == DepthCount);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign out_item = entry_ff[rd_ptr_ff];

   // pointer and count update, pointers wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

FILE: rtl/dop_classify.sv
// front end: decodes each option byte into the kind of record it would open
module dop_classify
   import dop_pkg::*;
(
   input  dop_req_type in_item,
   output dop_cls_type out_item
);

   // option code lookup
   always_comb begin
      out_item.opt_byte = in_item.opt_byte;
      out_item.last     = in_item.last;
      out_item.is_end   = (in_item.opt_byte == OPT_END);
      out_item.is_pad   = (in_item.opt_byte == OPT_PAD);
      unique case (in_item.opt_byte)
         OPT_MASK:    out_item.kind = KIND_MASK;
         OPT_ROUTER:  out_item.kind = KIND_ROUTER;
         OPT_DNS:     out_item.kind = KIND_DNS;
         OPT_LEASE:   out_item.kind = KIND_LEASE;
         OPT_MSGTYPE: out_item.kind = KIND_MSGTYPE;
         OPT_SERVER:  out_item.kind = KIND_SERVER;
         default:     out_item.kind = KIND_OTHER;
      endcase
   end

endmodule

FILE: rtl/dop_walker.sv
// back end: walks code/length/data records and keeps the captured values
module dop_walker
   import dop_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  dop_cls_type in_item,
   output logic        in_take,
   output logic        out_push,
   input  logic        out_full,
   output dop_rsp_type out_item
);

   dop_phase_type phase_ff, phase_in;
   dop_kind_type  kind_ff, kind_in;
   logic [7:0]    remain_ff, remain_in;
   logic [2:0]    index_ff, index_in;
   logic [31:0]   shift_ff, shift_in;
   logic [31:0]   mask_ff, mask_in;
   logic [31:0]   dns_ff, dns_in;
   logic [31:0]   router_ff, router_in;
   logic [31:0]   server_ff, server_in;
   logic [31:0]   lease_ff, lease_in;
   logic [7:0]    type_ff, type_in;
   logic          seen_type_ff, seen_type_in;
   logic          seen_lease_ff, seen_lease_in;
   logic          commit;
   logic [7:0]    first_byte;

   // take a byte unless it closes the area and the result queue is full
   assign in_take  = in_valid && (!in_item.last || !out_full);
   assign out_push = in_take && in_item.last;

   // first data byte of the record, from the bytes gathered so far
   always_comb begin
      unique case (index_in)
         3'd1:    first_byte = shift_in[7:0];
         3'd2:    first_byte = shift_in[15:8];
         3'd3:    first_byte = shift_in[23:16];
         3'd4:    first_byte = shift_in[31:24];
         default: first_byte = 8'd0;
      endcase
   end

   // record walk for one byte
   always_comb begin
      phase_in      = phase_ff;
      kind_in       = kind_ff;
      remain_in     = remain_ff;
      index_in      = index_ff;
      shift_in      = shift_ff;
      commit        = 1'b0;
      unique case (phase_ff)
         PH_CODE: begin
            if (in_item.is_end) begin
               phase_in = PH_DONE;
            end else if (!in_item.is_pad) begin
               kind_in  = in_item.kind;
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            remain_in = in_item.opt_byte;
            index_in  = 3'd0;
            shift_in  = 32'd0;
            if (in_item.opt_byte == 8'd0) begin
               commit   = 1'b1;
               phase_in = PH_CODE;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            if (index_ff < MAX_VALUE_BYTES) begin
               shift_in = {shift_ff[23:0], in_item.opt_byte};
               index_in = index_ff + 3'd1;
            end
            remain_in = remain_ff - 8'd1;
            if (remain_in == 8'd0) begin
               commit   = 1'b1;
               phase_in = PH_CODE;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // store a finished record
   always_comb begin
      mask_in       = mask_ff;
      dns_in        = dns_ff;
      router_in     = router_ff;
      server_in     = server_ff;
      lease_in      = lease_ff;
      type_in       = type_ff;
      seen_type_in  = seen_type_ff;
      seen_lease_in = seen_lease_ff;
      if (commit) begin
         unique case (kind_in)
            KIND_MASK:   mask_in   = shift_in;
            KIND_DNS:    dns_in    = shift_in;
            KIND_ROUTER: router_in = shift_in;
            KIND_SERVER: server_in = shift_in;
            KIND_LEASE: begin
               if (!seen_lease_ff) begin
                  lease_in      = shift_in;
                  seen_lease_in = 1'b1;
               end
            end
            KIND_MSGTYPE: begin
               if (!seen_type_ff) begin
                  type_in      = first_byte;
                  seen_type_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result from the state after this byte
   always_comb begin
      out_item.msg_type      = type_in;
      out_item.has_msg_type  = seen_type_in;
      out_item.subnet_mask   = mask_in;
      out_item.dns_server    = dns_in;
      out_item.router        = router_in;
      out_item.server_id     = server_in;
      out_item.lease_seconds = lease_in;
      out_item.has_lease     = seen_lease_in;
      out_item.truncated     = (phase_in == PH_LEN) || (phase_in == PH_DATA);
   end

   // state registers, cleared after the closing byte
   always_ff @(posedge clock) begin
      if (reset || out_push) begin
         phase_ff      <= PH_CODE;
         kind_ff       <= KIND_OTHER;
         remain_ff     <= '0;
         index_ff      <= '0;
         shift_ff      <= '0;
         mask_ff       <= '0;
         dns_ff        <= '0;
         router_ff     <= '0;
         server_ff     <= '0;
         lease_ff      <= '0;
         type_ff       <= '0;
         seen_type_ff  <= 1'b0;
         seen_lease_ff <= 1'b0;
      end else if (in_take) begin
         phase_ff      <= phase_in;
         kind_ff       <= kind_in;
         remain_ff     <= remain_in;
         index_ff      <= index_in;
         shift_ff      <= shift_in;
         mask_ff       <= mask_in;
         dns_ff        <= dns_in;
         router_ff     <= router_in;
         server_ff     <= server_in;
         lease_ff      <= lease_in;
         type_ff       <= type_in;
         seen_type_ff  <= seen_type_in;
         seen_lease_ff <= seen_lease_in;
      end
   end

endmodule

FILE: rtl/dhcp_option_parser.sv
// top level of the dhcp option parser: classifier, byte queue, walker, result queue
//
// Takes the options area of one DHCP message one byte per cycle and returns one
// result, holding message type, lease time, subnet mask, DNS server, router,
// server identifier and a truncation flag, for the byte marked last. A new byte
// is accepted every cycle while full is low; the walker handles one byte per
// cycle unless a closing byte meets a full result queue, so sustained rate is one
// byte per cycle while results are popped. A result enters the result queue when
// the walker takes its closing byte from the byte queue. Byte classification sits
// in front of a MID_DEPTH entry queue, and results wait in a RSP_DEPTH entry
// queue, so either side may stall without stopping the other at once.
module dhcp_option_parser
   import dop_pkg::*;
#(
   parameter int MID_DEPTH = MID_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = RSP_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  dop_req_type req_item,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output dop_rsp_type rsp_item
);

   dop_cls_type cls_item;
   dop_cls_type mid_item;
   logic        mid_empty;
   logic        mid_take;
   dop_rsp_type walk_item;
   logic        walk_push;
   logic        walk_full;

   // byte decode
   dop_classify u_classify (
      .in_item  (req_item),
      .out_item (cls_item)
   );

   // queue between front and back
   dop_queue #(
      .DEPTH     (MID_DEPTH),
      .item_type (dop_cls_type)
   ) u_mid_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .full     (req_full),
      .in_item  (cls_item),
      .pop      (mid_take),
      .empty    (mid_empty),
      .out_item (mid_item)
   );

   // record walker
   dop_walker u_walker (
      .clock    (clock),
      .reset    (reset),
      .in_valid (!mid_empty),
      .in_item  (mid_item),
      .in_take  (mid_take),
      .out_push (walk_push),
      .out_full (walk_full),
      .out_item (walk_item)
   );

   // results waiting for transfer
   dop_queue #(
      .DEPTH     (RSP_DEPTH),
      .item_type (dop_rsp_type)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (walk_push),
      .full     (walk_full),
      .in_item  (walk_item),
      .pop      (rsp_pop),
      .empty    (rsp_empty),
      .out_item (rsp_item)
   );

endmodule

FILE: test/dhcp_option_parser_checker.sv
// checker for the dhcp option parser: byte-walk predictor and parse summary compare
module dhcp_option_parser_checker
   import dop_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  dop_req_type req_item,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  dop_rsp_type rsp_item,
   output int          fail_count,
   output int          results_owed,
   output int          results_checked,
   output int          cut_results
);
   timeunit 1ns;
   timeprecision 1ps;

   // walker state of the predictor
   dop_phase_type walk_phase;
   logic [7:0]    rec_code;
   logic [7:0]    rec_left;
   logic [7:0]    first_val;
   logic [2:0]    val_bytes;
   logic [31:0]   val_acc;

   // captured option values
   logic [31:0]   mask_q;
   logic [31:0]   dns_q;
   logic [31:0]   router_q;
   logic [31:0]   server_q;
   logic [31:0]   lease_q;
   logic [7:0]    type_q;
   logic          type_seen;
   logic          lease_seen;

   dop_rsp_type   summaries_due[$];
   int            errs = 0;
   int            n_checked = 0;
   int            n_cut = 0;

   // back to the state right after reset
   function automatic void clear_walk();
      walk_phase = PH_CODE;
      rec_code   = '0;
      rec_left   = '0;
      first_val  = '0;
      val_bytes  = '0;
      val_acc    = '0;
      mask_q     = '0;
      dns_q      = '0;
      router_q   = '0;
      server_q   = '0;
      lease_q    = '0;
      type_q     = '0;
      type_seen  = 1'b0;
      lease_seen = 1'b0;
   endfunction

   // a complete record: last occurrence wins, except lease and message type
   function automatic void store_record();
      case (rec_code)
         OPT_MASK:   mask_q   = val_acc;
         OPT_DNS:    dns_q    = val_acc;
         OPT_ROUTER: router_q = val_acc;
         OPT_SERVER: server_q = val_acc;
         OPT_LEASE: begin
            if (!lease_seen) begin
               lease_q    = val_acc;
               lease_seen = 1'b1;
            end
         end
         OPT_MSGTYPE: begin
            if (!type_seen) begin
               type_q    = first_val;
               type_seen = 1'b1;
            end
         end
         default: ;
      endcase
      walk_phase = PH_CODE;
   endfunction

   // advance the walk by one accepted byte, queue a summary on the closing byte
   function automatic void walk_option_byte(dop_req_type it);
      dop_rsp_type s;
      case (walk_phase)
         PH_CODE: begin
            if (it.opt_byte == OPT_END) begin
               walk_phase = PH_DONE;
            end else if (it.opt_byte != OPT_PAD) begin
               rec_code   = it.opt_byte;
               walk_phase = PH_LEN;
            end
         end
         PH_LEN: begin
            rec_left  = it.opt_byte;
            val_bytes = '0;
            val_acc   = '0;
            first_val = '0;
            if (it.opt_byte == 8'd0) store_record();
            else walk_phase = PH_DATA;
         end
         PH_DATA: begin
            // only the first four value bytes count, the rest are skipped
            if (val_bytes < MAX_VALUE_BYTES) begin
               if (val_bytes == 3'd0) first_val = it.opt_byte;
               val_acc   = {val_acc[23:0], it.opt_byte};
               val_bytes = val_bytes + 3'd1;
            end
            rec_left = rec_left - 8'd1;
            if (rec_left == 8'd0) store_record();
         end
         default: ;
      endcase
      if (it.last) begin
         s.msg_type      = type_q;
         s.has_msg_type  = type_seen;
         s.subnet_mask   = mask_q;
         s.dns_server    = dns_q;
         s.router        = router_q;
         s.server_id     = server_q;
         s.lease_seconds = lease_q;
         s.has_lease     = lease_seen;
         s.truncated     = (walk_phase == PH_LEN) || (walk_phase == PH_DATA);
         summaries_due.push_back(s);
         clear_walk();
      end
   endfunction

   function automatic bit field_off(string tag, logic [31:0] seen, logic [31:0] want,
                                    bit loud);
      if (seen !== want) begin
         if (loud) $display("parse summary %0d: %s expected %0h got %0h",
                            n_checked, tag, want, seen);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // field by field compare of one popped summary
   function automatic void check_summary(dop_rsp_type seen, dop_rsp_type want);
      bit loud;
      bit off;
      loud = errs < 10;
      off  = field_off("msg_type", 32'(seen.msg_type), 32'(want.msg_type), loud)
           | field_off("has_msg_type", 32'(seen.has_msg_type), 32'(want.has_msg_type), loud)
           | field_off("subnet_mask", seen.subnet_mask, want.subnet_mask, loud)
           | field_off("dns_server", seen.dns_server, want.dns_server, loud)
           | field_off("router", seen.router, want.router, loud)
           | field_off("server_id", seen.server_id, want.server_id, loud)
           | field_off("lease_seconds", seen.lease_seconds, want.lease_seconds, loud)
           | field_off("has_lease", 32'(seen.has_lease), 32'(want.has_lease), loud)
           | field_off("truncated", 32'(seen.truncated), 32'(want.truncated), loud);
      if (off) errs++;
      if (want.truncated) n_cut++;
      n_checked++;
   endfunction

   initial clear_walk();

   // watch both channels; compare a popped summary before predicting from the byte taken alongside it
   always @(posedge clock) begin
      if (reset) begin
         clear_walk();
         summaries_due.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (summaries_due.size() == 0) begin
               errs++;
               if (errs <= 10) $display("parse summary popped with none outstanding");
            end else begin
               check_summary(rsp_item, summaries_due.pop_front());
            end
         end
         if (req_push && !req_full) walk_option_byte(req_item);
      end
      fail_count      <= errs;
      results_owed    <= summaries_due.size();
      results_checked <= n_checked;
      cut_results     <= n_cut;
   end

endmodule

FILE: test/tb_dhcp_option_parser.sv
// testbench top for the dhcp option parser: clock, reset, option byte stimulus, verdict
module tb_dhcp_option_parser;
   import dop_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BYTE_TARGET = 1150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   dop_req_type req_item = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   dop_rsp_type rsp_item;

   int fail_count;
   int results_owed;
   int results_checked;
   int cut_results;

   int send_idle = 27;
   int recv_idle = 45;
   int bytes_sent = 0;
   int frames_sent = 0;

   logic [7:0] frame_q[$];
   logic [7:0] known_codes[6] = '{OPT_MASK, OPT_ROUTER, OPT_DNS, OPT_LEASE, OPT_MSGTYPE,
                                  OPT_SERVER};

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dhcp_option_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   dhcp_option_parser_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_item        (req_item),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_item        (rsp_item),
      .fail_count      (fail_count),
      .results_owed    (results_owed),
      .results_checked (results_checked),
      .cut_results     (cut_results)
   );

   // result side stalls at random
   always @(posedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= recv_idle);
   end

   // one byte transfer, with random idle cycles in front
   task automatic push_byte(input logic [7:0] b, input logic fin);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= '{opt_byte: b, last: fin};
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_q[i]) push_byte(frame_q[i], i == frame_q.size() - 1);
      frames_sent++;
      frame_q.delete();
   endtask

   // stop sending until every summary is back, then let the pipe settle
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // code, length and the first few data bytes of a record
   task automatic add_record(input logic [7:0] code, input int len, input int keep);
      frame_q.push_back(code);
      frame_q.push_back(len[7:0]);
      repeat (keep) frame_q.push_back(8'($urandom_range(255)));
   endtask

   // mostly well-formed records, some noise, then end, a cut record or nothing
   task automatic build_random_frame();
      int pick;
      int len;
      int tail;
      int k;
      logic [7:0] code;
      repeat ($urandom_range(0, 6)) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            frame_q.push_back(OPT_PAD);
         end else if (pick < 80) begin
            len = ($urandom_range(9) < 7) ? 4 : $urandom_range(0, 7);
            add_record(known_codes[$urandom_range(5)], len, len);
         end else if (pick < 95) begin
            len = ($urandom_range(29) == 0) ? $urandom_range(11, 255) : $urandom_range(0, 10);
            add_record(8'($urandom_range(2, 254)), len, len);
         end else begin
            frame_q.push_back(8'($urandom_range(255)));
         end
      end
      tail = $urandom_range(99);
      code = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 254))
                                       : known_codes[$urandom_range(5)];
      if (tail < 60) begin
         frame_q.push_back(OPT_END);
         repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom_range(255)));
      end else if (tail < 78) begin
         k = $urandom_range(2);
         if (k == 0) begin
            frame_q.push_back(code);
         end else if (k == 1) begin
            frame_q.push_back(code);
            frame_q.push_back(8'($urandom_range(1, 255)));
         end else begin
            len = $urandom_range(2, 8);
            add_record(code, len, $urandom_range(1, len - 1));
         end
      end else if (frame_q.size() == 0) begin
         frame_q.push_back(8'($urandom_range(255)));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // pad, zero-length mask and message type, short dns, long router, junk after end
      frame_q = '{OPT_PAD, OPT_MASK, 8'd0, OPT_MSGTYPE, 8'd0, OPT_DNS, 8'd2, 8'hab, 8'hcd,
                  OPT_ROUTER, 8'd6, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66,
                  OPT_END, 8'hff};
      send_frame();
      // lease cut inside its data
      frame_q = '{OPT_LEASE, 8'd4, 8'h01, 8'h02};
      send_frame();
      // cut right after a code byte
      frame_q = '{OPT_SERVER};
      send_frame();
      // area ends between records with no end marker
      frame_q = '{OPT_MASK, 8'd1, 8'h80};
      send_frame();
      drain();

      // three idle mixes, with a full drain between them
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 27 : (ph == 1) ? 45 : 0;
         recv_idle = (ph == 0) ? 45 : (ph == 1) ? 27 : 0;
         while (bytes_sent < (ph + 1) * BYTE_TARGET / 3) begin
            build_random_frame();
            send_frame();
         end
         drain();
      end

      $display("run covered %0d option bytes in %0d frames under three stall mixes",
               bytes_sent, frames_sent);
      $display("%0d parse summaries compared, %0d of them for cut-short records",
               results_checked, cut_results);
      if (fail_count == 0 && results_owed == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog
   initial begin
      #3_000_000;
      $display("watchdog expired with %0d summaries outstanding", results_owed);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: dhcp_option_parser.f
rtl/dop_pkg.sv
rtl/dop_queue.sv
rtl/dop_classify.sv
rtl/dop_walker.sv
rtl/dhcp_option_parser.sv
test/dhcp_option_parser_checker.sv
test/tb_dhcp_option_parser.sv
